/* src/bpc_pkg.sv */
// shared types and constants for the barometric pressure compensation unit
// no dependencies
`default_nettype none
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [19:0]        pressure;
    logic               divide_fault;
  } result_t;

  // unpacked calibration, already sign or zero extended to 32 bits
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } cal_t;

  localparam logic [2:0] REG_AC1_AC2  = 3'd0;
  localparam logic [2:0] REG_AC3_AC4  = 3'd1;
  localparam logic [2:0] REG_AC5_AC6  = 3'd2;
  localparam logic [2:0] REG_B1_B2    = 3'd3;
  localparam logic [2:0] REG_MC_MD    = 3'd4;
  localparam logic [2:0] REG_OVERSAMP = 3'd5;

  localparam logic [1:0]  OSS_RESET  = 2'd2;
  localparam logic [31:0] C_4000     = 32'd4000;
  localparam logic [31:0] C_3038     = 32'd3038;
  localparam logic [31:0] C_M7357    = 32'hFFFF_E343;
  localparam logic [31:0] C_3791     = 32'd3791;
  localparam logic [31:0] C_50000    = 32'd50000;
  localparam logic [31:0] C_32768    = 32'd32768;
  localparam logic [31:0] C_SIGN     = 32'h8000_0000;
  localparam logic [31:0] P_MAX      = 32'd1048575;

endpackage
`default_nettype wire

/* src/bpc_front.sv */
// front end: takes items from the command port into a two entry queue
// depends on bpc_pkg
`default_nettype none
module bpc_front
  import bpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t in_item,
  output logic       busy,
  output logic       q_valid,
  output item_t      q_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  // back end never stalls, so an entry leaves every cycle it is present
  assign pop     = (count != 2'd0);
  assign q_valid = pop;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule
`default_nettype wire

/* src/bpc_div.sv */
// pipelined unsigned 32 by 32 divider, one quotient bit per stage
// carries a side tag along with each operation; no package use
`default_nettype none
module bpc_div #(
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [31:0]      num,
  input  wire logic [31:0]      den,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [31:0]           quot,
  output logic [TAG_W-1:0]      out_tag
);

  logic             vld [33];
  logic [31:0]      rem [33];
  logic [31:0]      nr  [33];
  logic [31:0]      dv  [33];
  logic [31:0]      qt  [33];
  logic [TAG_W-1:0] tg  [33];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign nr[0]  = num;
  assign dv[0]  = den;
  assign qt[0]  = '0;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    assign trial = {rem[k], nr[k][31]};
    assign diff  = trial - {1'b0, dv[k]};
    assign ge    = !diff[32];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[31:0] : trial[31:0];
      nr[k+1]  <= {nr[k][30:0], 1'b0};
      dv[k+1]  <= dv[k];
      qt[k+1]  <= {qt[k][30:0], ge};
      tg[k+1]  <= tg[k];
    end
  end

  assign out_valid = vld[32];
  assign quot      = qt[32];
  assign out_tag   = tg[32];

endmodule
`default_nettype wire

/* src/bpc_back.sv */
// back end: pipelined temperature and pressure compensation datapath
// depends on bpc_pkg and bpc_div
`default_nettype none
module bpc_back
  import bpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cal_t  cal,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       result_valid,
  output result_t    result
);

  // stage 1: first temperature product
  logic        v1;
  logic [31:0] x1a_1;
  logic [23:0] up_1;
  logic [23:0] up_in;
  assign up_in = in_item.raw_pressure >> (4'd8 - {2'b0, cal.oss});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    x1a_1 <= 32'(({16'b0, in_item.raw_temperature} - cal.ac6) * cal.ac5);
    up_1  <= up_in;
  end

  // stage 2: x1 and the temperature divisor
  logic        v2;
  logic [31:0] x1_2, d_2, n_2;
  logic [31:0] x1_c;
  logic [23:0] up_2;
  assign x1_c = $unsigned($signed(x1a_1) >>> 15);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end
  always_ff @(posedge clk) begin
    x1_2 <= x1_c;
    d_2  <= x1_c + cal.md;
    n_2  <= {cal.mc[20:0], 11'b0};
    up_2 <= up_1;
  end

  // first divider: signed quotient through magnitudes
  localparam int T1_W = 32 + 24 + 2;
  logic [T1_W-1:0] t1_in, t1_out;
  logic            dv1_valid;
  logic [31:0]     q1;
  logic [31:0]     ma1, mb1;
  logic            neg1;
  assign ma1   = n_2[31] ? 32'(-n_2) : n_2;
  assign mb1   = d_2[31] ? 32'(-d_2) : d_2;
  assign neg1  = n_2[31] ^ d_2[31];
  assign t1_in = {x1_2, up_2, neg1, (d_2 == 32'd0)};

  bpc_div #(.TAG_W(T1_W)) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .num      (ma1),
    .den      (mb1),
    .in_tag   (t1_in),
    .out_valid(dv1_valid),
    .quot     (q1),
    .out_tag  (t1_out)
  );

  logic [31:0] x1_d;
  logic [23:0] up_d;
  logic        neg_d, ft_d;
  assign {x1_d, up_d, neg_d, ft_d} = t1_out;

  // stage 3: b5
  logic        v3, ft_3;
  logic [31:0] b5_3;
  logic [23:0] up_3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= dv1_valid;
  end
  always_ff @(posedge clk) begin
    b5_3 <= x1_d + (neg_d ? 32'(-q1) : q1);
    up_3 <= up_d;
    ft_3 <= ft_d;
  end

  // stage 4: temperature and b6
  logic        v4, ft_4;
  logic [31:0] b6_4;
  logic [15:0] t_4;
  logic [23:0] up_4;
  logic [31:0] t_full;
  assign t_full = $unsigned($signed(b5_3 + 32'd8) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end
  always_ff @(posedge clk) begin
    b6_4 <= b5_3 - C_4000;
    ft_4 <= ft_3;
    up_4 <= up_3;
    if ($signed(t_full) > 32'sd32767)       t_4 <= 16'h7FFF;
    else if ($signed(t_full) < -32'sd32768) t_4 <= 16'h8000;
    else                                    t_4 <= t_full[15:0];
  end

  // stage 5: b6 squared and coefficient products
  logic        v5, ft_5;
  logic [31:0] sqr_5, ac2b6_5, ac3b6_5;
  logic [15:0] t_5;
  logic [23:0] up_5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end
  always_ff @(posedge clk) begin
    sqr_5   <= 32'(b6_4 * b6_4);
    ac2b6_5 <= 32'(cal.ac2 * b6_4);
    ac3b6_5 <= 32'(cal.ac3 * b6_4);
    ft_5    <= ft_4;
    t_5     <= t_4;
    up_5    <= up_4;
  end

  // stage 6: products with the scaled square
  logic        v6, ft_6;
  logic [31:0] sqb2_6, b1sq_6, x2a_6, x1c_6;
  logic [31:0] sq;
  logic [15:0] t_6;
  logic [23:0] up_6;
  assign sq = $unsigned($signed(sqr_5) >>> 12);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end
  always_ff @(posedge clk) begin
    sqb2_6 <= 32'(sq * cal.b2);
    b1sq_6 <= 32'(cal.b1 * sq);
    x2a_6  <= $unsigned($signed(ac2b6_5) >>> 11);
    x1c_6  <= $unsigned($signed(ac3b6_5) >>> 13);
    ft_6   <= ft_5;
    t_6    <= t_5;
    up_6   <= up_5;
  end

  // stage 7: b3 and the b4 factor
  logic        v7, ft_7;
  logic [31:0] b3_7, x3b_7;
  logic [31:0] x3a, b3_pre, x3b_pre;
  logic [15:0] t_7;
  logic [23:0] up_7;
  assign x3a     = $unsigned($signed(sqb2_6) >>> 11) + x2a_6;
  assign b3_pre  = (({cal.ac1[29:0], 2'b0} + x3a) << cal.oss) + 32'd2;
  assign x3b_pre = x1c_6 + $unsigned($signed(b1sq_6) >>> 16) + 32'd2;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
  end
  always_ff @(posedge clk) begin
    b3_7  <= $unsigned($signed(b3_pre) >>> 2);
    x3b_7 <= $unsigned($signed(x3b_pre) >>> 2);
    ft_7  <= ft_6;
    t_7   <= t_6;
    up_7  <= up_6;
  end

  // stage 8: b4 and b7 products
  logic        v8, ft_8;
  logic [31:0] b4m_8, b7_8;
  logic [15:0] t_8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
  end
  always_ff @(posedge clk) begin
    b4m_8 <= 32'(cal.ac4 * (x3b_7 + C_32768));
    b7_8  <= 32'(({8'b0, up_7} - b3_7) * (C_50000 >> cal.oss));
    ft_8  <= ft_7;
    t_8   <= t_7;
  end

  // second divider: unsigned b7 / b4 with the doubling placed by b7's top bit
  localparam int T2_W = 16 + 2;
  logic [31:0]     b4;
  logic            big7;
  logic [T2_W-1:0] t2_in, t2_out;
  logic            dv2_valid;
  logic [31:0]     q2;
  assign b4    = b4m_8 >> 15;
  assign big7  = (b7_8 >= C_SIGN);
  assign t2_in = {t_8, big7, ft_8 || (b4 == 32'd0)};

  bpc_div #(.TAG_W(T2_W)) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v8),
    .num      (big7 ? b7_8 : {b7_8[30:0], 1'b0}),
    .den      (b4),
    .in_tag   (t2_in),
    .out_valid(dv2_valid),
    .quot     (q2),
    .out_tag  (t2_out)
  );

  logic [15:0] t_d;
  logic        big_d, f_d;
  assign {t_d, big_d, f_d} = t2_out;

  // stage 9: p
  logic        v9, f_9;
  logic [31:0] p_9;
  logic [15:0] t_9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else     v9 <= dv2_valid;
  end
  always_ff @(posedge clk) begin
    p_9 <= big_d ? {q2[30:0], 1'b0} : q2;
    f_9 <= f_d;
    t_9 <= t_d;
  end

  // stage 10: correction products
  logic        v10, f_10;
  logic [31:0] pp_10, m2_10, p_10;
  logic [31:0] pa;
  logic [15:0] t_10;
  assign pa = $unsigned($signed(p_9) >>> 8);
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else     v10 <= v9;
  end
  always_ff @(posedge clk) begin
    pp_10 <= 32'(pa * pa);
    m2_10 <= 32'(p_9 * C_M7357);
    p_10  <= p_9;
    f_10  <= f_9;
    t_10  <= t_9;
  end

  // stage 11: square term times 3038
  logic        v11, f_11;
  logic [31:0] m1_11, x2_11, p_11;
  logic [15:0] t_11;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else     v11 <= v10;
  end
  always_ff @(posedge clk) begin
    m1_11 <= 32'(pp_10 * C_3038);
    x2_11 <= $unsigned($signed(m2_10) >>> 16);
    p_11  <= p_10;
    f_11  <= f_10;
    t_11  <= t_10;
  end

  // stage 12: final pressure, saturation and fault masking
  logic [31:0] corr, pf;
  assign corr = $unsigned($signed($unsigned($signed(m1_11) >>> 16) + x2_11 + C_3791) >>> 4);
  assign pf   = p_11 + corr;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= v11;
  end
  always_ff @(posedge clk) begin
    if (f_11) begin
      result.temperature  <= '0;
      result.pressure     <= '0;
      result.divide_fault <= 1'b1;
    end else begin
      result.temperature  <= t_11;
      result.divide_fault <= 1'b0;
      if (pf[31])                  result.pressure <= '0;
      else if (pf > P_MAX)         result.pressure <= P_MAX[19:0];
      else                         result.pressure <= pf[19:0];
    end
  end

endmodule
`default_nettype wire

/* src/barometric_pressure_compensation_unit.sv */
// top level of the barometric pressure compensation unit: register file and wiring
// depends on bpc_pkg, bpc_front, bpc_back (and bpc_div below it)
//
// usage
//   item channel: drive in_item and raise start; the item is taken at a
//     clock edge where start is high and busy is low
//   result channel: result_valid is high for one cycle with the compensated
//     temperature, pressure and divide_fault; the receiver cannot stall, so
//     the datapath never stops
//   config: apb-style port, registers at byte addresses 4*i in the order
//     ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md, oversampling; write only
//     while no item is in flight; pready is tied high
// timing
//   one item per cycle sustained; the path from acceptance to result_valid is
//   12 datapath register stages (the first one reads the input queue) and two
//   32-stage dividers (one quotient bit per stage)
//   busy only rises if the two-entry input queue fills, which the always
//   draining datapath does not allow in practice
// reset
//   rst is synchronous, active high; clears the queue and all stage valids,
//   calibration goes to zero and oversampling to 2
`default_nettype none
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        start,
  input  wire item_t       in_item,
  output logic             busy,
  // result channel
  output logic             result_valid,
  output result_t          result,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] cal_ac1_ac2;
  logic [31:0] cal_ac3_ac4;
  logic [31:0] cal_ac5_ac6;
  logic [31:0] cal_b1_b2;
  logic [31:0] cal_mc_md;
  logic [1:0]  oversampling;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2  <= '0;
      cal_ac3_ac4  <= '0;
      cal_ac5_ac6  <= '0;
      cal_b1_b2    <= '0;
      cal_mc_md    <= '0;
      oversampling <= OSS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AC1_AC2:  cal_ac1_ac2  <= pwdata;
        REG_AC3_AC4:  cal_ac3_ac4  <= pwdata;
        REG_AC5_AC6:  cal_ac5_ac6  <= pwdata;
        REG_B1_B2:    cal_b1_b2    <= pwdata;
        REG_MC_MD:    cal_mc_md    <= pwdata;
        REG_OVERSAMP: oversampling <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_AC1_AC2:  prdata = cal_ac1_ac2;
      REG_AC3_AC4:  prdata = cal_ac3_ac4;
      REG_AC5_AC6:  prdata = cal_ac5_ac6;
      REG_B1_B2:    prdata = cal_b1_b2;
      REG_MC_MD:    prdata = cal_mc_md;
      REG_OVERSAMP: prdata = {30'b0, oversampling};
      default:      prdata = '0;
    endcase
  end

  // coefficients unpacked with their signedness
  cal_t cal;
  assign cal.ac1 = {{16{cal_ac1_ac2[31]}}, cal_ac1_ac2[31:16]};
  assign cal.ac2 = {{16{cal_ac1_ac2[15]}}, cal_ac1_ac2[15:0]};
  assign cal.ac3 = {{16{cal_ac3_ac4[31]}}, cal_ac3_ac4[31:16]};
  assign cal.ac4 = {16'b0, cal_ac3_ac4[15:0]};
  assign cal.ac5 = {16'b0, cal_ac5_ac6[31:16]};
  assign cal.ac6 = {16'b0, cal_ac5_ac6[15:0]};
  assign cal.b1  = {{16{cal_b1_b2[31]}}, cal_b1_b2[31:16]};
  assign cal.b2  = {{16{cal_b1_b2[15]}}, cal_b1_b2[15:0]};
  assign cal.mc  = {{16{cal_mc_md[31]}}, cal_mc_md[31:16]};
  assign cal.md  = {{16{cal_mc_md[15]}}, cal_mc_md[15:0]};
  assign cal.oss = oversampling;

  // front end queue into the datapath
  logic  q_valid;
  item_t q_item;

  bpc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .q_valid(q_valid),
    .q_item (q_item)
  );

  bpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cal         (cal),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire
